// ===== rtl/hpc_pkg.sv =====
package hpc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_BITS_DEF   = 16;

  // fixed field widths
  localparam int LIN_W    = 32;
  localparam int SHIFT_W  = 32;
  localparam int PERSP_W  = 40;
  localparam int WEIGHT_W = 32;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int SCALE_W    = 32;
  localparam int PMAX_W     = 48;

  typedef enum logic [1:0] {
    REG_SCALE_MIN = 2'd0,
    REG_SCALE_MAX = 2'd1,
    REG_PERSP_MAX = 2'd2
  } reg_idx_t;

  localparam logic [SCALE_W-1:0] SCALE_MIN_RST = 32'd167772;
  localparam logic [SCALE_W-1:0] SCALE_MAX_RST = 32'd268435456;
  localparam logic [PMAX_W-1:0]  PERSP_MAX_RST = 48'd1125899907;

endpackage

// ===== rtl/hpc_in_if.sv =====
interface hpc_in_if #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [hpc_pkg::LIN_W-1:0]    lin_xx;
  logic signed [hpc_pkg::LIN_W-1:0]    lin_xy;
  logic signed [hpc_pkg::SHIFT_W-1:0]  shift_x;
  logic signed [hpc_pkg::LIN_W-1:0]    lin_yx;
  logic signed [hpc_pkg::LIN_W-1:0]    lin_yy;
  logic signed [hpc_pkg::SHIFT_W-1:0]  shift_y;
  logic signed [hpc_pkg::PERSP_W-1:0]  persp_x;
  logic signed [hpc_pkg::PERSP_W-1:0]  persp_y;
  logic signed [hpc_pkg::WEIGHT_W-1:0] persp_w;
  logic        [COORD_BITS-1:0]        point_x;
  logic        [COORD_BITS-1:0]        point_y;

  modport source (
    output valid, lin_xx, lin_xy, shift_x, lin_yx, lin_yy, shift_y,
           persp_x, persp_y, persp_w, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, lin_xx, lin_xy, shift_x, lin_yx, lin_yy, shift_y,
           persp_x, persp_y, persp_w, point_x, point_y,
    output ready
  );
endinterface

// ===== rtl/hpc_out_if.sv =====
interface hpc_out_if #(
  parameter int OUT_BITS = hpc_pkg::OUT_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] mapped_x;
  logic signed [OUT_BITS-1:0] mapped_y;
  logic                       plausible;

  modport source (output valid, mapped_x, mapped_y, plausible, input ready);
  modport sink   (input valid, mapped_x, mapped_y, plausible, output ready);
endinterface

// ===== rtl/homography_point_check.sv =====
// homography point check
// in_ch: one beat carries a 3x3 homography (nine fixed-point terms) and
// one source pixel; out_ch: one beat per input beat with the projected
// pixel (saturated to OUT_BITS signed; rounded half up when positive,
// else its quotient drops by one if nonzero with remainder under half)
// and a plausibility flag (positive determinant, column scales in
// bounds, small perspective, nonzero denominator). a zero denominator
// gives 0, 0, 0. throughput: one beat per cycle while out_ch is accepted.
// the restoring dividers take one quotient bit per stage, OUT_BITS stages.
// every stage holds its own valid bit and loads whenever it is empty or
// its successor moves, so bubbles collapse and in_ch.ready stays high
// while the output register waits on a stalled receiver until the pipe
// is full; nothing is dropped or repeated.
// reset (rst, synchronous) empties the pipeline and loads the default
// bounds. config registers on the apb port at 8*i: scale_min_sq,
// scale_max_sq, persp_max_sq; write them only while the block is idle.
module homography_point_check #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF,
  parameter int OUT_BITS   = hpc_pkg::OUT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hpc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  hpc_in_if.sink                          in_ch,
  hpc_out_if.source                       out_ch
);

  localparam int LW     = hpc_pkg::LIN_W;
  localparam int PW     = hpc_pkg::PERSP_W;
  localparam int CW     = COORD_BITS + 1;           // point as signed
  localparam int LP_W   = LW + CW;                  // lin term times point
  localparam int PP_W   = PW + CW;                  // persp term times point
  localparam int NUM_W  = LW + COORD_BITS + 3;      // numerator at 2^24
  localparam int NMAG_W = NUM_W + 14;               // numerator at 2^38
  localparam int DEN_W  = PW + COORD_BITS + 3;      // denominator at 2^38
  localparam int REM_W  = (NMAG_W > DEN_W) ? NMAG_W : DEN_W;
  localparam int QB     = OUT_BITS;                 // quotient bits
  localparam int SQ_W   = 2 * LW;
  localparam int SCL_W  = 2 * LW;                   // sum of two squares
  localparam int HALF   = PW / 2;
  localparam int PSQ_W  = 2 * PW;
  localparam int PS_W   = PSQ_W + 2;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [hpc_pkg::SCALE_W-1:0] scale_min_sq;
  logic [hpc_pkg::SCALE_W-1:0] scale_max_sq;
  logic [hpc_pkg::PMAX_W-1:0]  persp_max_sq;
  hpc_pkg::reg_idx_t           reg_sel;

  assign reg_sel = hpc_pkg::reg_idx_t'(paddr[4:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_min_sq <= hpc_pkg::SCALE_MIN_RST;
      scale_max_sq <= hpc_pkg::SCALE_MAX_RST;
      persp_max_sq <= hpc_pkg::PERSP_MAX_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        hpc_pkg::REG_SCALE_MIN: scale_min_sq <= pwdata[hpc_pkg::SCALE_W-1:0];
        hpc_pkg::REG_SCALE_MAX: scale_max_sq <= pwdata[hpc_pkg::SCALE_W-1:0];
        hpc_pkg::REG_PERSP_MAX: persp_max_sq <= pwdata[hpc_pkg::PMAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      hpc_pkg::REG_SCALE_MIN: prdata = hpc_pkg::CFG_DATA_W'(scale_min_sq);
      hpc_pkg::REG_SCALE_MAX: prdata = hpc_pkg::CFG_DATA_W'(scale_max_sq);
      hpc_pkg::REG_PERSP_MAX: prdata = hpc_pkg::CFG_DATA_W'(persp_max_sq);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // flow control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------
  logic          v1, v2, v3, v5;
  logic [QB-1:0] dvv;
  logic          go1, go2, go3, go5, go6;
  logic [QB-1:0] godv;

  assign go6 = !out_ch.valid || out_ch.ready;
  assign go5 = !v5 || go6;
  assign go3 = !v3 || godv[0];
  assign go2 = !v2 || go3;
  assign go1 = !v1 || go2;
  assign in_ch.ready = go1;

  // ---------------------------------------------------------------
  // stage 1: all products
  // ---------------------------------------------------------------
  logic signed [CW-1:0]   px_s, py_s;
  logic signed [HALF-1:0] phx, phy;                 // upper halves, signed
  logic signed [HALF:0]   plx, ply;                 // lower halves, as signed

  assign px_s = $signed({1'b0, in_ch.point_x});
  assign py_s = $signed({1'b0, in_ch.point_y});
  assign phx  = in_ch.persp_x[PW-1:HALF];
  assign phy  = in_ch.persp_y[PW-1:HALF];
  assign plx  = $signed({1'b0, in_ch.persp_x[HALF-1:0]});
  assign ply  = $signed({1'b0, in_ch.persp_y[HALF-1:0]});

  logic signed [LP_W-1:0]        mxx1, mxy1, myx1, myy1;
  logic signed [PP_W-1:0]        mdx1, mdy1;
  logic signed [hpc_pkg::SHIFT_W-1:0]  tx1, ty1;
  logic signed [hpc_pkg::WEIGHT_W-1:0] pw1;
  logic signed [SQ_W-1:0]        deta1, detb1;
  logic signed [SQ_W-1:0]        sqxx1, sqyx1, sqxy1, sqyy1;
  logic signed [2*HALF-1:0]      pax1, pay1;
  logic signed [2*HALF:0]        pbx1, pby1;
  logic        [2*HALF-1:0]      pcx1, pcy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (go1) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      mxx1  <= in_ch.lin_xx * px_s;
      mxy1  <= in_ch.lin_xy * py_s;
      myx1  <= in_ch.lin_yx * px_s;
      myy1  <= in_ch.lin_yy * py_s;
      mdx1  <= in_ch.persp_x * px_s;
      mdy1  <= in_ch.persp_y * py_s;
      tx1   <= in_ch.shift_x;
      ty1   <= in_ch.shift_y;
      pw1   <= in_ch.persp_w;
      deta1 <= in_ch.lin_xx * in_ch.lin_yy;
      detb1 <= in_ch.lin_xy * in_ch.lin_yx;
      sqxx1 <= in_ch.lin_xx * in_ch.lin_xx;
      sqyx1 <= in_ch.lin_yx * in_ch.lin_yx;
      sqxy1 <= in_ch.lin_xy * in_ch.lin_xy;
      sqyy1 <= in_ch.lin_yy * in_ch.lin_yy;
      // perspective squares split into 20-bit halves
      pax1  <= phx * phx;
      pay1  <= phy * phy;
      pbx1  <= phx * plx;
      pby1  <= phy * ply;
      pcx1  <= in_ch.persp_x[HALF-1:0] * in_ch.persp_x[HALF-1:0];
      pcy1  <= in_ch.persp_y[HALF-1:0] * in_ch.persp_y[HALF-1:0];
    end
  end

  // ---------------------------------------------------------------
  // stage 2: numerators, denominator, sums of squares
  // ---------------------------------------------------------------
  logic signed [NUM_W-1:0] numx2, numy2;
  logic signed [DEN_W-1:0] den2;
  logic                    det2;
  logic [SCL_W-1:0]        sxx2, syy2;
  logic [PSQ_W-1:0]        psq2;
  logic signed [PS_W-1:0]  psum;

  always_comb begin
    psum = PS_W'($signed({pax1, {(2*HALF){1'b0}}}))
         + PS_W'($signed({pbx1, {(HALF+1){1'b0}}}))
         + PS_W'($signed({1'b0, pcx1}))
         + PS_W'($signed({pay1, {(2*HALF){1'b0}}}))
         + PS_W'($signed({pby1, {(HALF+1){1'b0}}}))
         + PS_W'($signed({1'b0, pcy1}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (go2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      numx2 <= NUM_W'(mxx1) + NUM_W'(mxy1) + NUM_W'($signed({tx1, 8'h00}));
      numy2 <= NUM_W'(myx1) + NUM_W'(myy1) + NUM_W'($signed({ty1, 8'h00}));
      den2  <= DEN_W'(mdx1) + DEN_W'(mdy1) + DEN_W'($signed({pw1, 14'h0000}));
      det2  <= deta1 > detb1;
      sxx2  <= SCL_W'(sqxx1[SQ_W-2:0]) + SCL_W'(sqyx1[SQ_W-2:0]);
      syy2  <= SCL_W'(sqxy1[SQ_W-2:0]) + SCL_W'(sqyy1[SQ_W-2:0]);
      psq2  <= psum[PSQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // stage 3: magnitudes, signs, plausibility compares
  // ---------------------------------------------------------------
  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [QB-1:0]    q_x;
    logic [REM_W-1:0] rem_y;
    logic [QB-1:0]    q_y;
    logic [DEN_W-1:0] dmag;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             ok;
    logic             zero;
  } dv_t;

  logic [NUM_W-1:0]  absx, absy;
  logic [DEN_W-1:0]  absd;
  logic [SCL_W-1:0]  lo_bound, hi_bound;
  logic [PSQ_W-1:0]  p_bound;
  logic              zero_c, ok_c;
  dv_t               st3;

  always_comb begin
    absx     = numx2[NUM_W-1] ? NUM_W'(-numx2) : NUM_W'(numx2);
    absy     = numy2[NUM_W-1] ? NUM_W'(-numy2) : NUM_W'(numy2);
    absd     = den2[DEN_W-1] ? DEN_W'(-den2) : DEN_W'(den2);
    lo_bound = SCL_W'({scale_min_sq, 24'h000000});
    hi_bound = SCL_W'({scale_max_sq, 24'h000000});
    p_bound  = PSQ_W'({persp_max_sq, 28'h0000000});
    zero_c   = (den2 == '0);
    ok_c     = det2 && !zero_c
            && (sxx2 >= lo_bound) && (sxx2 <= hi_bound)
            && (syy2 >= lo_bound) && (syy2 <= hi_bound)
            && (psq2 <= p_bound);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (go3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      st3.rem_x <= REM_W'({absx, 14'h0000});
      st3.rem_y <= REM_W'({absy, 14'h0000});
      st3.q_x   <= '0;
      st3.q_y   <= '0;
      st3.dmag  <= absd;
      st3.neg_x <= (numx2 != '0) && (numx2[NUM_W-1] != den2[DEN_W-1]);
      st3.neg_y <= (numy2 != '0) && (numy2[NUM_W-1] != den2[DEN_W-1]);
      st3.ovf_x <= 1'b0;
      st3.ovf_y <= 1'b0;
      st3.ok    <= ok_c;
      st3.zero  <= zero_c;
    end
  end

  // ---------------------------------------------------------------
  // restoring dividers: one quotient bit per stage, msb first;
  // the first stage also flags quotients beyond QB bits
  // ---------------------------------------------------------------
  dv_t dv [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int BIT = QB - 1 - j;
    dv_t src, nxt;
    logic src_v;

    if (j == 0) begin : g_first
      assign src   = st3;
      assign src_v = v3;
    end else begin : g_next
      assign src   = dv[j-1];
      assign src_v = dvv[j-1];
    end

    if (j == QB - 1) begin : g_go_last
      assign godv[j] = !dvv[j] || go5;
    end else begin : g_go
      assign godv[j] = !dvv[j] || godv[j+1];
    end

    always_comb begin
      nxt = src;
      if (j == 0) begin
        nxt.ovf_x = (src.rem_x >> QB) >= REM_W'(src.dmag);
        nxt.ovf_y = (src.rem_y >> QB) >= REM_W'(src.dmag);
      end
      if ((src.rem_x >> BIT) >= REM_W'(src.dmag)) begin
        nxt.rem_x    = src.rem_x - (REM_W'(src.dmag) << BIT);
        nxt.q_x[BIT] = 1'b1;
      end
      if ((src.rem_y >> BIT) >= REM_W'(src.dmag)) begin
        nxt.rem_y    = src.rem_y - (REM_W'(src.dmag) << BIT);
        nxt.q_y[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j] <= 1'b0;
      end else if (godv[j]) begin
        dvv[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (godv[j]) begin
        dv[j] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 5: positives round half up; negatives drop one if nonzero under half, on magnitudes
  // ---------------------------------------------------------------
  dv_t             dl;
  logic [REM_W:0]  twice_rx, twice_ry, dwide;
  logic [QB:0]     magx5, magy5;
  logic            negx5, negy5, ovfx5, ovfy5, ok5, zero5;

  always_comb begin
    dl       = dv[QB-1];
    twice_rx = {dl.rem_x, 1'b0};
    twice_ry = {dl.rem_y, 1'b0};
    dwide    = (REM_W+1)'(dl.dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (go5) begin
      v5 <= dvv[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (go5) begin
      if (!dl.neg_x) begin
        magx5 <= (QB+1)'(dl.q_x) + (QB+1)'(twice_rx >= dwide);
      end else begin
        magx5 <= (QB+1)'(dl.q_x)
               - (QB+1)'((dl.q_x != '0) && (twice_rx < dwide));
      end
      if (!dl.neg_y) begin
        magy5 <= (QB+1)'(dl.q_y) + (QB+1)'(twice_ry >= dwide);
      end else begin
        magy5 <= (QB+1)'(dl.q_y)
               - (QB+1)'((dl.q_y != '0) && (twice_ry < dwide));
      end
      negx5 <= dl.neg_x;
      negy5 <= dl.neg_y;
      ovfx5 <= dl.ovf_x;
      ovfy5 <= dl.ovf_y;
      ok5   <= dl.ok;
      zero5 <= dl.zero;
    end
  end

  // ---------------------------------------------------------------
  // output register: sign, saturation, zero-denominator override
  // ---------------------------------------------------------------
  localparam logic [QB:0] POS_LIM = (QB+1)'((1 << (OUT_BITS - 1)) - 1);
  localparam logic [QB:0] NEG_LIM = (QB+1)'(1) << (OUT_BITS - 1);
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = POS_LIM[OUT_BITS-1:0];
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = NEG_LIM[OUT_BITS-1:0];

  logic signed [OUT_BITS-1:0] resx, resy;

  always_comb begin
    priority if (zero5) begin
      resx = '0;
    end else if (!negx5) begin
      resx = (ovfx5 || magx5 > POS_LIM) ? OUT_MAX : magx5[OUT_BITS-1:0];
    end else begin
      resx = (ovfx5 || magx5 > NEG_LIM) ? OUT_MIN : OUT_BITS'(-magx5);
    end
    priority if (zero5) begin
      resy = '0;
    end else if (!negy5) begin
      resy = (ovfy5 || magy5 > POS_LIM) ? OUT_MAX : magy5[OUT_BITS-1:0];
    end else begin
      resy = (ovfy5 || magy5 > NEG_LIM) ? OUT_MIN : OUT_BITS'(-magy5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (go6) begin
      out_ch.valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (go6) begin
      out_ch.mapped_x  <= resx;
      out_ch.mapped_y  <= resy;
      out_ch.plausible <= ok5 && !zero5;
    end
  end

endmodule
